// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_CLK_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/sbplh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbplh_pkg
// Shared constants, types and tables of the spectrum band peak unit.
// ----------------------------------------------------------------------------
package sbplh_pkg;

   localparam int BAND_COUNT        = 16;
   localparam int BIN_COUNT         = 256;
   localparam int DEF_HISTORY_DEPTH = 16;
   localparam int BAND_W            = 4;
   localparam int BIN_W             = 8;
   localparam int MAG_W             = 16;
   localparam int HEIGHT_W          = 16;
   localparam int GAIN_W            = 16;
   localparam int AGE_W             = 4;
   localparam int PEAK_SHIFT        = 7;
   localparam int LN2_Q16           = 45426;
   localparam int FRAC_W            = 16;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
   localparam logic [BIN_W-1:0]  CLOSE_BIN  = BIN_W'(BIN_COUNT - 1);
   localparam logic [BAND_W-1:0] LAST_BAND  = BAND_W'(BAND_COUNT - 1);

   localparam logic [BIN_W-1:0] BAND_EDGE [BAND_COUNT+1] = '{
      8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14, 8'd20, 8'd28,
      8'd40, 8'd54, 8'd74, 8'd101, 8'd137, 8'd187, 8'd255
   };

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef struct packed {
      logic              is_rd;
      logic [BAND_W-1:0] band;
      logic              done;
      logic [MAG_W-1:0]  peak;
   } item_type;

   // log2 fraction of a normalized 9-bit value, indexed by the bits below the top one
   typedef logic [FRAC_W-1:0] frac_tbl_type [256];

   function automatic frac_tbl_type build_frac_tbl();
      frac_tbl_type t;
      logic [63:0]  x;
      logic [FRAC_W-1:0] f;
      for (int m = 0; m < 256; m++) begin
         x = 64'(256 + m) << 22;
         f = '0;
         for (int i = FRAC_W - 1; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= 64'h0000_0000_8000_0000) begin
               x    = x >> 1;
               f[i] = 1'b1;
            end
         end
         t[m] = f;
      end
      return t;
   endfunction

   localparam frac_tbl_type LOG2_FRAC_TBL = build_frac_tbl();

endpackage

// ===== hw/rtl/sbplh_band_track.sv =====
// ----------------------------------------------------------------------------
// sbplh_band_track
// Band lookup, running peak and history row tracking for each accepted item.
// ----------------------------------------------------------------------------
module sbplh_band_track #(
   parameter int HISTORY_DEPTH = sbplh_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        accept,
   input  logic                                        cmd,
   input  logic [sbplh_pkg::BIN_W-1:0]                 bin_index,
   input  logic [sbplh_pkg::MAG_W-1:0]                 bin_magnitude,
   input  logic [sbplh_pkg::AGE_W-1:0]                 read_age,
   input  logic [sbplh_pkg::BAND_W-1:0]                read_band,
   output logic                                        item_valid,
   output sbplh_pkg::item_type                         item,
   output logic [$clog2(HISTORY_DEPTH*sbplh_pkg::BAND_COUNT)-1:0] item_addr
);
   import sbplh_pkg::*;

   localparam int RowW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int AddrW = $clog2(HISTORY_DEPTH * BAND_COUNT);

   typedef logic [RowW-1:0] age_tbl_type [16];

   function automatic age_tbl_type build_age_tbl();
      age_tbl_type t;
      for (int a = 0; a < 16; a++) begin
         t[a] = RowW'(a % HISTORY_DEPTH);
      end
      return t;
   endfunction

   localparam age_tbl_type AGE_MOD = build_age_tbl();

   logic [MAG_W-1:0]  peak_ff, peak_in;
   logic [BAND_W-1:0] cur_band_ff, cur_band_in;
   logic [RowW-1:0]   write_row_ff, write_row_in;

   logic [BAND_W-1:0] band_w;
   logic              is_read;
   logic              is_close;
   logic              is_first;
   logic              is_last;
   logic [MAG_W-1:0]  peak_new;
   logic [RowW-1:0]   age_mod;
   logic [RowW:0]     rd_sum;
   logic [RowW-1:0]   rd_row;
   logic [RowW-1:0]   row_sel;
   logic [RowW+BAND_W-1:0] addr_full;

   always_comb begin
      band_w = '0;
      for (int i = 0; i < BAND_COUNT; i++) begin
         if (bin_index >= BAND_EDGE[i]) begin
            band_w = BAND_W'(i);
         end
      end
   end

   assign is_read  = (cmd == CMD_READ);
   assign is_close = (bin_index == CLOSE_BIN);
   assign is_first = (bin_index == BAND_EDGE[{1'b0, band_w}]);
   assign is_last  = ({1'b0, bin_index} + 9'd1)
                     == {1'b0, BAND_EDGE[{1'b0, band_w} + 5'd1]};

   always_comb begin
      if (is_first || (band_w != cur_band_ff)) begin
         peak_new = bin_magnitude;
      end else if (bin_magnitude > peak_ff) begin
         peak_new = bin_magnitude;
      end else begin
         peak_new = peak_ff;
      end
   end

   // row of age a is (write_row - 1 - a) mod depth
   assign age_mod = AGE_MOD[read_age];
   assign rd_sum  = (RowW+1)'(write_row_ff) + (RowW+1)'(HISTORY_DEPTH - 1)
                    - (RowW+1)'(age_mod);
   assign rd_row  = (rd_sum >= (RowW+1)'(HISTORY_DEPTH))
                    ? RowW'(rd_sum - (RowW+1)'(HISTORY_DEPTH)) : rd_sum[RowW-1:0];

   assign item_valid  = is_read || (!is_close && is_last);
   assign item.is_rd  = is_read;
   assign item.band   = is_read ? read_band : band_w;
   assign item.done   = !is_read && is_last && (band_w == LAST_BAND);
   assign item.peak   = peak_new;

   assign row_sel   = is_read ? rd_row : write_row_ff;
   assign addr_full = {row_sel, item.band};
   assign item_addr = addr_full[AddrW-1:0];

   always_comb begin
      peak_in      = peak_ff;
      cur_band_in  = cur_band_ff;
      write_row_in = write_row_ff;
      if (accept && !is_read) begin
         if (is_close) begin
            peak_in     = '0;
            cur_band_in = '0;
         end else begin
            peak_in     = peak_new;
            cur_band_in = band_w;
            if (item.done) begin
               write_row_in = (write_row_ff == RowW'(HISTORY_DEPTH - 1))
                              ? '0 : write_row_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         cur_band_ff  <= '0;
         write_row_ff <= '0;
      end else begin
         peak_ff      <= peak_in;
         cur_band_ff  <= cur_band_in;
         write_row_ff <= write_row_in;
      end
   end

endmodule

// ===== hw/rtl/sbplh_log_pipe.sv =====
// ----------------------------------------------------------------------------
// sbplh_log_pipe
// Three-stage log height pipeline: log2 lookup, ln scaling, gain multiply.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbplh_log_pipe #(
   parameter int AddrW = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [sbplh_pkg::GAIN_W-1:0]   gain_scale,
   input  logic                           in_valid,
   input  sbplh_pkg::item_type            in_item,
   input  logic [AddrW-1:0]               in_addr,
   output logic                           in_ready,
   input  logic                           out_ready,
   output logic                           s3_valid,
   output sbplh_pkg::item_type            s3_item,
   output logic [AddrW-1:0]               s3_addr,
   output logic [sbplh_pkg::HEIGHT_W-1:0] s3_height
);
   import sbplh_pkg::*;

   localparam int PW   = MAG_W - PEAK_SHIFT;
   localparam int L2_W = BAND_W + FRAC_W;

   logic            s1_valid_ff, s1_valid_in;
   item_type        s1_item_ff;
   logic [AddrW-1:0] s1_addr_ff;

   logic            s2_valid_ff, s2_valid_in;
   item_type        s2_item_ff;
   logic [AddrW-1:0] s2_addr_ff;
   logic [L2_W-1:0] s2_l2_ff, s2_l2_in;

   logic            s3_valid_ff, s3_valid_in;
   item_type        s3_item_ff;
   logic [AddrW-1:0] s3_addr_ff;
   logic [HEIGHT_W-1:0] s3_ln_ff, s3_ln_in;

   logic en1, en2, en3;

   logic [PW-1:0]     p_w;
   logic [BAND_W-1:0] k_w;
   logic [PW-1:0]     norm_w;
   logic [35:0]       ln_prod;
   logic [32:0]       h_prod;

   assign en3 = !s3_valid_ff || out_ready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign in_ready = en1;

   assign s1_valid_in = en1 ? in_valid    : s1_valid_ff;
   assign s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = en3 ? s2_valid_ff : s3_valid_ff;

   // log2 of the shifted peak: top bit index and table fraction
   assign p_w = s1_item_ff.peak[MAG_W-1:PEAK_SHIFT];

   always_comb begin
      k_w = '0;
      for (int i = 0; i < PW; i++) begin
         if (p_w[i]) begin
            k_w = BAND_W'(i);
         end
      end
   end

   assign norm_w   = p_w << (BAND_W'(PW - 1) - k_w);
   assign s2_l2_in = {k_w, LOG2_FRAC_TBL[norm_w[PW-2:0]]};

   // ln in Q3.13
   assign ln_prod  = 36'(s2_l2_ff) * 36'(LN2_Q16) + 36'(1 << 18);
   assign s3_ln_in = ln_prod[34:19];

   // gain in Q4.12, rounded to Q8.8
   assign h_prod    = 33'(s3_ln_ff) * 33'(gain_scale) + 33'(1 << 16);
   assign s3_height = h_prod[32:17];

   assign s3_valid = s3_valid_ff;
   assign s3_item  = s3_item_ff;
   assign s3_addr  = s3_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_item_ff <= in_item;
         s1_addr_ff <= in_addr;
      end
      if (en2) begin
         s2_item_ff <= s1_item_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_l2_ff   <= s2_l2_in;
      end
      if (en3) begin
         s3_item_ff <= s2_item_ff;
         s3_addr_ff <= s2_addr_ff;
         s3_ln_ff   <= s3_ln_in;
      end
   end

   `ASSERT_CLK(a_s3_hold, s3_valid_ff && !out_ready |=> s3_valid_ff && $stable(s3_addr_ff), "stalled item left stage three")
   `ASSERT_CLK(a_s2_hold, s2_valid_ff && !en3 |=> s2_valid_ff && $stable(s2_l2_ff), "stalled item left stage two")

endmodule

// ===== hw/rtl/sbplh_hist_mem.sv =====
// ----------------------------------------------------------------------------
// sbplh_hist_mem
// Waterfall history memory, one port, registered read, zero sweep after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbplh_hist_mem #(
   parameter int HISTORY_DEPTH = sbplh_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           mem_we,
   input  logic                           mem_re,
   input  logic [$clog2(HISTORY_DEPTH*sbplh_pkg::BAND_COUNT)-1:0] mem_addr,
   input  logic [sbplh_pkg::HEIGHT_W-1:0] mem_wdata,
   output logic [sbplh_pkg::HEIGHT_W-1:0] mem_rdata,
   output logic                           clr_busy
);
   import sbplh_pkg::*;

   localparam int Depth = HISTORY_DEPTH * BAND_COUNT;
   localparam int AddrW = $clog2(Depth);

   logic [HEIGHT_W-1:0] mem [Depth];
   logic [HEIGHT_W-1:0] rdata_ff;
   logic                clr_busy_ff, clr_busy_in;
   logic [AddrW-1:0]    clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AddrW'(Depth - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;
   assign clr_busy  = clr_busy_ff;

   `ASSERT_CLK(a_no_access_clr, clr_busy_ff |-> !(mem_we || mem_re), "memory access during clear sweep")
   `ASSERT_CLK(a_clr_once, !clr_busy_ff |=> !clr_busy_ff, "clear sweep restarted without reset")
   `ASSERT_CLK_NR(a_clr_after_reset, reset |=> clr_busy_ff && (clr_addr_ff == '0), "reset did not start sweep")

endmodule

// ===== hw/rtl/spectrum_band_peak_log_history_unit.sv =====
// ----------------------------------------------------------------------------
// spectrum_band_peak_log_history_unit
// An accepted item passes stages s1, s2, s3 and the output register to rsp_*.
// Throughput: one item per cycle while rsp_ready holds and no clear sweep runs,
// set by the three-stage log pipeline and the single history memory port that a
// write or a read uses in the last stage. Reset: peak, band and row state clear
// at once; then all HISTORY_DEPTH*16 words (256 by default) are zeroed, req_ready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_band_peak_log_history_unit #(
   parameter int HISTORY_DEPTH = sbplh_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [sbplh_pkg::GAIN_W-1:0]   csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [sbplh_pkg::BIN_W-1:0]    req_bin_index,
   input  logic [sbplh_pkg::MAG_W-1:0]    req_bin_magnitude,
   input  logic [sbplh_pkg::AGE_W-1:0]    req_read_age,
   input  logic [sbplh_pkg::BAND_W-1:0]   req_read_band,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_is_readback,
   output logic [sbplh_pkg::BAND_W-1:0]   rsp_band,
   output logic [sbplh_pkg::HEIGHT_W-1:0] rsp_height,
   output logic                           rsp_frame_done
);
   import sbplh_pkg::*;

   localparam int AddrW = $clog2(HISTORY_DEPTH * BAND_COUNT);

   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic                out_valid_ff, out_valid_in;
   item_type            out_item_ff;
   logic [HEIGHT_W-1:0] out_height_ff;

   logic                accept;
   logic                bt_valid;
   item_type            bt_item;
   logic [AddrW-1:0]    bt_addr;
   logic                pipe_ready;
   logic                out_en;
   logic                s3_valid;
   item_type            s3_item;
   logic [AddrW-1:0]    s3_addr;
   logic [HEIGHT_W-1:0] s3_height;
   logic                mem_we;
   logic                mem_re;
   logic [HEIGHT_W-1:0] mem_rdata;
   logic                mem_busy;

   assign req_ready = pipe_ready && !mem_busy;
   assign accept    = req_valid && req_ready;
   assign out_en    = !out_valid_ff || rsp_ready;

   sbplh_band_track #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_band_track (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cmd           (req_cmd),
      .bin_index     (req_bin_index),
      .bin_magnitude (req_bin_magnitude),
      .read_age      (req_read_age),
      .read_band     (req_read_band),
      .item_valid    (bt_valid),
      .item          (bt_item),
      .item_addr     (bt_addr)
   );

   sbplh_log_pipe #(
      .AddrW (AddrW)
   ) u_log_pipe (
      .clock      (clock),
      .reset      (reset),
      .gain_scale (gain_ff),
      .in_valid   (accept && bt_valid),
      .in_item    (bt_item),
      .in_addr    (bt_addr),
      .in_ready   (pipe_ready),
      .out_ready  (out_en),
      .s3_valid   (s3_valid),
      .s3_item    (s3_item),
      .s3_addr    (s3_addr),
      .s3_height  (s3_height)
   );

   assign mem_we = s3_valid && out_en && !s3_item.is_rd;
   assign mem_re = s3_valid && out_en && s3_item.is_rd;

   sbplh_hist_mem #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (s3_addr),
      .mem_wdata (s3_height),
      .mem_rdata (mem_rdata),
      .clr_busy  (mem_busy)
   );

   assign gain_in      = csr_write_enable ? csr_write_data : gain_ff;
   assign out_valid_in = out_en ? s3_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_item_ff   <= s3_item;
         out_height_ff <= s3_height;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_is_readback = out_item_ff.is_rd;
   assign rsp_band        = out_item_ff.band;
   assign rsp_frame_done  = out_item_ff.done;
   assign rsp_height      = out_item_ff.is_rd ? mem_rdata : out_height_ff;

   `ASSERT_CLK(a_done_band,
               rsp_valid && rsp_frame_done |-> !rsp_is_readback && (rsp_band == LAST_BAND),
               "frame done on wrong item")

endmodule
